>>> sv/sv32ptw_pkg.sv
// ---------------------------------------------------------------------------
// sv32ptw_pkg
// Shared types and constants of the Sv32 page table walker.
// ---------------------------------------------------------------------------
package sv32ptw_pkg;

  localparam int unsigned Levels     = 2;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 20;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_TRANSLATE_EN = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROOT_PAGE    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SUM          = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MXR          = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MPRV         = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MPP          = 3'd5;

  // access kinds
  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;
  localparam logic [1:0] ACC_BAD   = 2'd3;

  // privilege levels
  localparam logic [1:0] PRIV_USER    = 2'd0;
  localparam logic [1:0] PRIV_MACHINE = 2'd3;

  // input actions
  localparam logic ACT_REQUEST  = 1'b0;
  localparam logic ACT_RESPONSE = 1'b1;

  // trap causes
  localparam logic [3:0] CAUSE_FETCH_PF = 4'd12;
  localparam logic [3:0] CAUSE_LOAD_PF  = 4'd13;
  localparam logic [3:0] CAUSE_STORE_PF = 4'd15;

  // pte bit positions
  localparam int unsigned PTE_V = 0;
  localparam int unsigned PTE_R = 1;
  localparam int unsigned PTE_W = 2;
  localparam int unsigned PTE_X = 3;
  localparam int unsigned PTE_U = 4;
  localparam int unsigned PTE_A = 6;
  localparam int unsigned PTE_D = 7;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_FAULT = 2'd3
  } kind_e;

  // one queued record: an optional entry write, then the final result
  typedef struct packed {
    kind_e       kind;
    logic        has_write;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic [31:0] phys_addr;
    logic [3:0]  fault_cause;
    logic [31:0] fault_addr;
  } rec_t;

  function automatic logic [3:0] cause_of(input logic [1:0] acs);
    logic [3:0] c;
    case (acs)
      ACC_FETCH: c = CAUSE_FETCH_PF;
      ACC_LOAD:  c = CAUSE_LOAD_PF;
      default:   c = CAUSE_STORE_PF;
    endcase
    return c;
  endfunction

endpackage

>>> sv/sv32_page_table_walker_core.sv
// Sv32 page table walker. Takes one translate request or memory response per
// cycle while the queue has room; results leave through a registered output
// one per cycle while the receiver is ready, so an item that updates the A/D
// bits (write transfer followed by done) occupies the output for both
// transfers. A two-entry record queue between the classifying front end and
// the output stage absorbs that; sustained input rate is one item per cycle
// unless the output side stalls or most items need entry updates.
// ---------------------------------------------------------------------------
// sv32_page_table_walker_core
// Top level: front end, record queue and output stage.
// ---------------------------------------------------------------------------
module sv32_page_table_walker_core import sv32ptw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [31:0]         virt_addr_i,
  input  logic [1:0]          access_kind_i,
  input  logic [1:0]          priv_level_i,
  input  logic [31:0]         entry_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [31:0]         mem_addr_o,
  output logic [31:0]         mem_wdata_o,
  output logic [31:0]         phys_addr_o,
  output logic [3:0]          fault_cause_o,
  output logic [31:0]         fault_addr_o,
  output logic                last_o
);

  logic accept;
  logic push, q_ready, q_valid, pop;
  rec_t front_rec, head_rec;

  assign in_ready_o = q_ready;
  assign accept     = in_valid_i && q_ready;

  sv32ptw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .action_i     (action_i),
    .virt_addr_i  (virt_addr_i),
    .access_kind_i(access_kind_i),
    .priv_level_i (priv_level_i),
    .entry_word_i (entry_word_i),
    .push_o       (push),
    .rec_o        (front_rec)
  );

  sv32ptw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (front_rec),
    .ready_o(q_ready),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rec_o  (head_rec)
  );

  sv32ptw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_valid_i  (q_valid),
    .rec_i        (head_rec),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .mem_addr_o   (mem_addr_o),
    .mem_wdata_o  (mem_wdata_o),
    .phys_addr_o  (phys_addr_o),
    .fault_cause_o(fault_cause_o),
    .fault_addr_o (fault_addr_o),
    .last_o       (last_o)
  );

endmodule

>>> sv/sv32ptw_front.sv
// ---------------------------------------------------------------------------
// sv32ptw_front
// Holds configuration and walk state, classifies each item and builds the
// record of results it causes.
// ---------------------------------------------------------------------------
module sv32ptw_front import sv32ptw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                accept_i,
  input  logic                action_i,
  input  logic [31:0]         virt_addr_i,
  input  logic [1:0]          access_kind_i,
  input  logic [1:0]          priv_level_i,
  input  logic [31:0]         entry_word_i,
  output logic                push_o,
  output rec_t                rec_o
);

  logic        translate_enable_q;
  logic [19:0] root_table_page_q;
  logic        user_access_ok_q;
  logic        exec_readable_q;
  logic        modify_privilege_q;
  logic [1:0]  previous_privilege_q;

  logic        busy_q, busy_d;
  logic        level_q, level_d;
  logic [31:0] vaddr_q, vaddr_d;
  logic [1:0]  skind_q, skind_d;
  logic [1:0]  eprv_q, eprv_d;
  logic [31:0] eaddr_q, eaddr_d;

  logic        has_res;
  logic [1:0]  ep;
  logic        bypass;
  logic        pte_bad, is_ptr, u_fail, perm_ok, mega_bad, fault;
  logic [31:0] upd;

  always_comb begin
    rec_o   = '0;
    has_res = 1'b0;
    busy_d  = busy_q;
    level_d = level_q;
    vaddr_d = vaddr_q;
    skind_d = skind_q;
    eprv_d  = eprv_q;
    eaddr_d = eaddr_q;

    ep = (modify_privilege_q && access_kind_i != ACC_FETCH) ? previous_privilege_q
                                                            : priv_level_i;
    bypass = !translate_enable_q || priv_level_i == PRIV_MACHINE || ep[1];

    pte_bad = !entry_word_i[PTE_V] || (entry_word_i[PTE_W:PTE_R] == 2'b10);
    is_ptr  = !entry_word_i[PTE_X] && !entry_word_i[PTE_R];
    if (eprv_q == PRIV_USER) begin
      u_fail = !entry_word_i[PTE_U];
    end else begin
      u_fail = entry_word_i[PTE_U] && (skind_q == ACC_FETCH || !user_access_ok_q);
    end
    case (skind_q)
      ACC_FETCH: perm_ok = entry_word_i[PTE_X];
      ACC_LOAD:  perm_ok = entry_word_i[PTE_R] | (exec_readable_q & entry_word_i[PTE_X]);
      default:   perm_ok = entry_word_i[PTE_W];
    endcase
    mega_bad = level_q && (entry_word_i[19:10] != 10'd0);
    fault = pte_bad || (is_ptr && !level_q) || (!is_ptr && (u_fail || !perm_ok || mega_bad));

    upd = entry_word_i;
    upd[PTE_A] = 1'b1;
    if (skind_q == ACC_STORE) begin
      upd[PTE_D] = 1'b1;
    end

    if (action_i == ACT_REQUEST) begin
      has_res = 1'b1;
      busy_d  = 1'b0;
      if (bypass) begin
        rec_o.kind      = KIND_DONE;
        rec_o.phys_addr = virt_addr_i;
      end else begin
        vaddr_d = virt_addr_i;
        skind_d = access_kind_i;
        eprv_d  = ep;
        if (access_kind_i == ACC_BAD) begin
          rec_o.kind        = KIND_FAULT;
          rec_o.fault_cause = cause_of(access_kind_i);
          rec_o.fault_addr  = virt_addr_i;
        end else begin
          busy_d         = 1'b1;
          level_d        = 1'(Levels - 1);
          eaddr_d        = {root_table_page_q, virt_addr_i[31:22], 2'b00};
          rec_o.kind     = KIND_READ;
          rec_o.mem_addr = eaddr_d;
        end
      end
    end else if (busy_q) begin
      has_res = 1'b1;
      if (fault) begin
        busy_d            = 1'b0;
        rec_o.kind        = KIND_FAULT;
        rec_o.fault_cause = cause_of(skind_q);
        rec_o.fault_addr  = vaddr_q;
      end else if (is_ptr) begin
        level_d        = 1'b0;
        eaddr_d        = {entry_word_i[29:10], vaddr_q[21:12], 2'b00};
        rec_o.kind     = KIND_READ;
        rec_o.mem_addr = eaddr_d;
      end else begin
        busy_d          = 1'b0;
        rec_o.kind      = KIND_DONE;
        rec_o.has_write = (upd != entry_word_i);
        rec_o.mem_addr  = eaddr_q;
        rec_o.mem_wdata = upd;
        // megapage keeps the low 22 bits of the virtual address
        rec_o.phys_addr = level_q ? {entry_word_i[29:20], vaddr_q[21:0]}
                                  : {entry_word_i[29:10], vaddr_q[11:0]};
      end
    end
  end

  assign push_o = accept_i && has_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      translate_enable_q   <= 1'b0;
      root_table_page_q    <= '0;
      user_access_ok_q     <= 1'b0;
      exec_readable_q      <= 1'b0;
      modify_privilege_q   <= 1'b0;
      previous_privilege_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRANSLATE_EN: translate_enable_q   <= cfg_wdata_i[0];
        CFG_ROOT_PAGE:    root_table_page_q    <= cfg_wdata_i;
        CFG_SUM:          user_access_ok_q     <= cfg_wdata_i[0];
        CFG_MXR:          exec_readable_q      <= cfg_wdata_i[0];
        CFG_MPRV:         modify_privilege_q   <= cfg_wdata_i[0];
        CFG_MPP:          previous_privilege_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= 1'b1;
      vaddr_q <= '0;
      skind_q <= '0;
      eprv_q  <= '0;
      eaddr_q <= '0;
    end else if (accept_i) begin
      busy_q  <= busy_d;
      level_q <= level_d;
      vaddr_q <= vaddr_d;
      skind_q <= skind_d;
      eprv_q  <= eprv_d;
      eaddr_q <= eaddr_d;
    end
  end

endmodule

>>> sv/sv32ptw_queue.sv
// ---------------------------------------------------------------------------
// sv32ptw_queue
// Short register queue of result records between front and back.
// ---------------------------------------------------------------------------
module sv32ptw_queue import sv32ptw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output rec_t rec_o
);

  rec_t                 entries_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign ready_o = (count_q != QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign rec_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> sv/sv32ptw_back.sv
// ---------------------------------------------------------------------------
// sv32ptw_back
// Drains queued records into the output register, splitting a record with
// an entry update into a write transfer and a final transfer.
// ---------------------------------------------------------------------------
module sv32ptw_back import sv32ptw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rec_valid_i,
  input  rec_t        rec_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] mem_addr_o,
  output logic [31:0] mem_wdata_o,
  output logic [31:0] phys_addr_o,
  output logic [3:0]  fault_cause_o,
  output logic [31:0] fault_addr_o,
  output logic        last_o
);

  logic        valid_q;
  logic        phase_q;
  kind_e       kind_q;
  logic [31:0] mem_addr_q, mem_wdata_q, phys_addr_q, fault_addr_q;
  logic [3:0]  cause_q;
  logic        last_q;
  logic        load;
  logic        emit_write;

  assign load       = !valid_q || out_ready_i;
  assign emit_write = rec_i.has_write && !phase_q;
  assign pop_o      = load && rec_valid_i && !emit_write;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else if (load) begin
      valid_q <= rec_valid_i;
      if (rec_valid_i) begin
        phase_q <= emit_write;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && rec_valid_i) begin
      if (emit_write) begin
        kind_q       <= KIND_WRITE;
        mem_addr_q   <= rec_i.mem_addr;
        mem_wdata_q  <= rec_i.mem_wdata;
        phys_addr_q  <= '0;
        cause_q      <= '0;
        fault_addr_q <= '0;
        last_q       <= 1'b0;
      end else begin
        kind_q       <= rec_i.kind;
        // only a read transfer carries an address on the final beat
        mem_addr_q   <= (rec_i.kind == KIND_READ) ? rec_i.mem_addr : '0;
        mem_wdata_q  <= '0;
        phys_addr_q  <= rec_i.phys_addr;
        cause_q      <= rec_i.fault_cause;
        fault_addr_q <= rec_i.fault_addr;
        last_q       <= 1'b1;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = kind_q;
  assign mem_addr_o    = mem_addr_q;
  assign mem_wdata_o   = mem_wdata_q;
  assign phys_addr_o   = phys_addr_q;
  assign fault_cause_o = cause_q;
  assign fault_addr_o  = fault_addr_q;
  assign last_o        = last_q;

endmodule

>>> tb/sv32_walk_checker.sv
// ---------------------------------------------------------------------------
// sv32_walk_checker
// Watches the configuration port and both channels of the Sv32 walker,
// predicts every result from its own copy of the registers and walk state,
// and compares each output transfer field by field with the oldest
// prediction.
// ---------------------------------------------------------------------------
module sv32_walk_checker import sv32ptw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                action_i,
  input  logic [31:0]         virt_addr_i,
  input  logic [1:0]          access_kind_i,
  input  logic [1:0]          priv_level_i,
  input  logic [31:0]         entry_word_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [1:0]          kind_i,
  input  logic [31:0]         mem_addr_i,
  input  logic [31:0]         mem_wdata_i,
  input  logic [31:0]         phys_addr_i,
  input  logic [3:0]          fault_cause_i,
  input  logic [31:0]         fault_addr_i,
  input  logic                last_i,
  output int unsigned         outstanding_o,
  output int unsigned         mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_e       kind;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic [31:0] phys_addr;
    logic [3:0]  fault_cause;
    logic [31:0] fault_addr;
    logic        last;
  } walk_result_t;

  walk_result_t walk_results_q[$];

  // register copy
  logic        xlate_on = 1'b0;
  logic [19:0] root_ppn = '0;
  logic        sum_bit  = 1'b0;
  logic        mxr_bit  = 1'b0;
  logic        mprv_bit = 1'b0;
  logic [1:0]  mpp_bits = '0;

  // walk state
  logic        walking   = 1'b0;
  logic        at_root   = 1'b1;
  logic [31:0] walk_va   = '0;
  logic [1:0]  walk_acs  = '0;
  logic [1:0]  walk_priv = '0;
  logic [31:0] entry_ptr = '0;

  int unsigned results_owed   = 0;
  int unsigned mismatch_count = 0;

  assign outstanding_o = results_owed;
  assign mismatches_o  = mismatch_count;

  task automatic push_result(input kind_e kind, input logic [31:0] maddr,
                             input logic [31:0] wdata, input logic [31:0] paddr,
                             input logic [3:0] cause, input logic [31:0] faddr,
                             input logic last);
    walk_result_t r;
    r.kind        = kind;
    r.mem_addr    = maddr;
    r.mem_wdata   = wdata;
    r.phys_addr   = paddr;
    r.fault_cause = cause;
    r.fault_addr  = faddr;
    r.last        = last;
    walk_results_q.push_back(r);
  endtask

  task automatic page_fault();
    logic [3:0] cause;
    walking = 1'b0;
    if (walk_acs == ACC_FETCH) begin
      cause = CAUSE_FETCH_PF;
    end else if (walk_acs == ACC_LOAD) begin
      cause = CAUSE_LOAD_PF;
    end else begin
      cause = CAUSE_STORE_PF;
    end
    push_result(KIND_FAULT, '0, '0, '0, cause, walk_va, 1'b1);
  endtask

  task automatic walk_request(input logic [31:0] va, input logic [1:0] acs,
                              input logic [1:0] pl);
    logic [1:0] eff;
    eff = (mprv_bit && acs != ACC_FETCH) ? mpp_bits : pl;
    walking = 1'b0;
    if (!xlate_on || pl == PRIV_MACHINE || eff[1]) begin
      push_result(KIND_DONE, '0, '0, va, '0, '0, 1'b1);
      return;
    end
    walk_va   = va;
    walk_acs  = acs;
    walk_priv = eff;
    if (acs == ACC_BAD) begin
      page_fault();
      return;
    end
    walking   = 1'b1;
    at_root   = 1'b1;
    entry_ptr = {root_ppn, va[31:22], 2'b00};
    push_result(KIND_READ, entry_ptr, '0, '0, '0, '0, 1'b1);
  endtask

  task automatic walk_response(input logic [31:0] pte);
    logic        allowed;
    logic [31:0] upd;
    logic [31:0] pa;
    if (!walking) return;
    if (!pte[PTE_V] || (pte[PTE_W] && !pte[PTE_R])) begin
      page_fault();
      return;
    end
    // no R and no X: pointer to the next level
    if (!pte[PTE_R] && !pte[PTE_X]) begin
      if (!at_root) begin
        page_fault();
        return;
      end
      at_root   = 1'b0;
      entry_ptr = {pte[29:10], walk_va[21:12], 2'b00};
      push_result(KIND_READ, entry_ptr, '0, '0, '0, '0, 1'b1);
      return;
    end
    if (walk_priv == PRIV_USER) begin
      if (!pte[PTE_U]) begin
        page_fault();
        return;
      end
    end else if (pte[PTE_U] && (walk_acs == ACC_FETCH || !sum_bit)) begin
      page_fault();
      return;
    end
    case (walk_acs)
      ACC_FETCH: allowed = pte[PTE_X];
      ACC_LOAD:  allowed = pte[PTE_R] | (mxr_bit & pte[PTE_X]);
      default:   allowed = pte[PTE_W];
    endcase
    if (!allowed || (at_root && pte[19:10] != '0)) begin
      page_fault();
      return;
    end
    upd = pte;
    upd[PTE_A] = 1'b1;
    if (walk_acs == ACC_STORE) upd[PTE_D] = 1'b1;
    if (upd != pte) push_result(KIND_WRITE, entry_ptr, upd, '0, '0, '0, 1'b0);
    if (at_root) begin
      pa = {pte[29:10], 12'h000} | {10'h000, walk_va[21:0]};
    end else begin
      pa = {pte[29:10], walk_va[11:0]};
    end
    walking = 1'b0;
    push_result(KIND_DONE, '0, '0, pa, '0, '0, 1'b1);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic compare_result();
    walk_result_t want;
    if (walk_results_q.size() == 0) begin
      $error("result transfer with nothing expected: kind %0d", kind_i);
      mismatch_count++;
      return;
    end
    want = walk_results_q.pop_front();
    check_field("kind", 32'(want.kind), 32'(kind_i));
    check_field("mem_addr", want.mem_addr, mem_addr_i);
    check_field("mem_wdata", want.mem_wdata, mem_wdata_i);
    check_field("phys_addr", want.phys_addr, phys_addr_i);
    check_field("fault_cause", 32'(want.fault_cause), 32'(fault_cause_i));
    check_field("fault_addr", want.fault_addr, fault_addr_i);
    check_field("last", 32'(want.last), 32'(last_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlate_on  = 1'b0;
      root_ppn  = '0;
      sum_bit   = 1'b0;
      mxr_bit   = 1'b0;
      mprv_bit  = 1'b0;
      mpp_bits  = '0;
      walking   = 1'b0;
      at_root   = 1'b1;
      walk_va   = '0;
      walk_acs  = '0;
      walk_priv = '0;
      entry_ptr = '0;
      walk_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRANSLATE_EN: xlate_on = cfg_wdata_i[0];
          CFG_ROOT_PAGE:    root_ppn = cfg_wdata_i[19:0];
          CFG_SUM:          sum_bit  = cfg_wdata_i[0];
          CFG_MXR:          mxr_bit  = cfg_wdata_i[0];
          CFG_MPRV:         mprv_bit = cfg_wdata_i[0];
          CFG_MPP:          mpp_bits = cfg_wdata_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (action_i == ACT_REQUEST) begin
          walk_request(virt_addr_i, access_kind_i, priv_level_i);
        end else begin
          walk_response(entry_word_i);
        end
      end
      if (out_valid_i && out_ready_i) compare_result();
    end
    results_owed = walk_results_q.size();
  end

endmodule

>>> tb/tb_sv32_page_table_walker_core.sv
// ---------------------------------------------------------------------------
// tb_sv32_page_table_walker_core
// Drives directed and random translate requests and page table responses
// into the walker under several register settings, with random gaps and
// stalls on both channels, and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module tb_sv32_page_table_walker_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sv32ptw_pkg::*;

  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned MaxGap       = 4;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned RandomItems  = 450;
  localparam int unsigned NumPhases    = 8;

  localparam logic [1:0] PRIV_SUPER    = 2'd1;
  localparam logic [1:0] PRIV_RESERVED = 2'd2;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                action = ACT_REQUEST;
  logic [31:0]         virt_addr = '0;
  logic [1:0]          access_kind = ACC_FETCH;
  logic [1:0]          priv_level = PRIV_USER;
  logic [31:0]         entry_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          kind;
  logic [31:0]         mem_addr;
  logic [31:0]         mem_wdata;
  logic [31:0]         phys_addr;
  logic [3:0]          fault_cause;
  logic [31:0]         fault_addr;
  logic                last;

  int unsigned outstanding;
  int unsigned mismatches;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          hold_out    = 1'b0;
  bit          no_gaps     = 1'b0;
  bit          no_stalls   = 1'b0;

  always #2 clk = ~clk;

  sv32_page_table_walker_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .action_i      (action),
    .virt_addr_i   (virt_addr),
    .access_kind_i (access_kind),
    .priv_level_i  (priv_level),
    .entry_word_i  (entry_word),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .phys_addr_o   (phys_addr),
    .fault_cause_o (fault_cause),
    .fault_addr_o  (fault_addr),
    .last_o        (last)
  );

  sv32_walk_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .action_i      (action),
    .virt_addr_i   (virt_addr),
    .access_kind_i (access_kind),
    .priv_level_i  (priv_level),
    .entry_word_i  (entry_word),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .kind_i        (kind),
    .mem_addr_i    (mem_addr),
    .mem_wdata_i   (mem_wdata),
    .phys_addr_i   (phys_addr),
    .fault_cause_i (fault_cause),
    .fault_addr_i  (fault_addr),
    .last_i        (last),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  // ends the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("[sv32_page_table_walker_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stalls, and one long hold-off when asked
  initial begin : result_side
    int unsigned stall;
    bit          took;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_out = 1'b0;
      end
      stall = no_stalls ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  task automatic offer(input logic act, input logic [31:0] va, input logic [1:0] acs,
                       input logic [1:0] pl, input logic [31:0] pte);
    int unsigned gap;
    bit          took;
    gap = no_gaps ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    virt_addr   <= va;
    access_kind <= acs;
    priv_level  <= pl;
    entry_word  <= pte;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic apply_setting(input logic te, input logic [19:0] root, input logic sum,
                               input logic mxr, input logic mprv, input logic [1:0] mpp);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_TRANSLATE_EN;
    cfg_wdata <= CfgDataW'(te);
    @(posedge clk);
    cfg_idx   <= CFG_ROOT_PAGE;
    cfg_wdata <= root;
    @(posedge clk);
    cfg_idx   <= CFG_SUM;
    cfg_wdata <= CfgDataW'(sum);
    @(posedge clk);
    cfg_idx   <= CFG_MXR;
    cfg_wdata <= CfgDataW'(mxr);
    @(posedge clk);
    cfg_idx   <= CFG_MPRV;
    cfg_wdata <= CfgDataW'(mprv);
    @(posedge clk);
    cfg_idx   <= CFG_MPP;
    cfg_wdata <= CfgDataW'(mpp);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] leaf_pte(input bit mega);
    logic [31:0] pte;
    logic [2:0]  rwx;
    pte = $urandom;
    rwx = 3'($urandom_range(1, 7));
    // write without read is reserved; keep it rarer than the legal encodings
    if (rwx == 3'b010 || rwx == 3'b110) rwx = 3'($urandom_range(1, 7));
    pte[PTE_X:PTE_R] = rwx;
    pte[PTE_V] = ($urandom_range(0, 15) != 0);
    if (mega && $urandom_range(0, 3) != 0) pte[19:10] = '0;
    return pte;
  endfunction

  function automatic logic [31:0] pointer_pte();
    logic [31:0] pte;
    pte = $urandom;
    pte[PTE_V] = 1'b1;
    pte[PTE_R] = 1'b0;
    pte[PTE_X] = 1'b0;
    pte[PTE_W] = ($urandom_range(0, 15) == 0);
    return pte;
  endfunction

  // one translate request followed by a mostly well-formed walk
  task automatic random_walk();
    logic [1:0]  acs;
    logic [1:0]  pl;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    acs  = (pick == 0) ? ACC_BAD : 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      pl = PRIV_USER;
    end else if (pick < 8) begin
      pl = PRIV_SUPER;
    end else if (pick == 8) begin
      pl = PRIV_RESERVED;
    end else begin
      pl = PRIV_MACHINE;
    end
    offer(ACT_REQUEST, $urandom, acs, pl, $urandom);
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      offer(ACT_RESPONSE, $urandom, 2'($urandom), 2'($urandom), leaf_pte(1'b1));
    end else if (pick < 7) begin
      offer(ACT_RESPONSE, $urandom, 2'($urandom), 2'($urandom), pointer_pte());
      offer(ACT_RESPONSE, $urandom, 2'($urandom), 2'($urandom), leaf_pte(1'b0));
    end else if (pick == 7) begin
      offer(ACT_RESPONSE, $urandom, 2'($urandom), 2'($urandom), pointer_pte());
      offer(ACT_RESPONSE, $urandom, 2'($urandom), 2'($urandom), pointer_pte());
    end else if (pick == 8) begin
      // walk left open, the next request replaces it
      offer(ACT_RESPONSE, $urandom, 2'($urandom), 2'($urandom), pointer_pte());
    end else begin
      offer(ACT_RESPONSE, $urandom, 2'($urandom), 2'($urandom), $urandom);
      offer(ACT_RESPONSE, $urandom, 2'($urandom), 2'($urandom), $urandom);
    end
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    bit          paused;
    paused = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // translation off after reset, then a response with no walk open
    offer(ACT_REQUEST, 32'hffff_ffff, ACC_STORE, PRIV_USER, 32'h0000_0000);
    offer(ACT_RESPONSE, 32'h0000_0000, ACC_FETCH, PRIV_USER, 32'hffff_ffff);
    drain();
    apply_setting(1'b1, 20'hfffff, 1'b0, 1'b0, 1'b0, PRIV_USER);
    offer(ACT_REQUEST, 32'h0000_0000, ACC_FETCH, PRIV_MACHINE, 32'h0);
    offer(ACT_REQUEST, 32'h1234_5678, ACC_BAD, PRIV_SUPER, 32'h0);
    // pointer, then a pointer at the last level
    offer(ACT_REQUEST, 32'hffff_ffff, ACC_LOAD, PRIV_USER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'hffff_fc01);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'hffff_fc01);
    // megapage store: A and D written back
    offer(ACT_REQUEST, 32'h0040_0abc, ACC_STORE, PRIV_SUPER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'hfff0_0007);
    // A already set on a fetch: done only
    offer(ACT_REQUEST, 32'h0000_0123, ACC_FETCH, PRIV_USER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'h0000_0059);
    // new request drops the open walk
    offer(ACT_REQUEST, 32'h0000_1000, ACC_LOAD, PRIV_SUPER, 32'h0);
    offer(ACT_REQUEST, 32'h8000_0000, ACC_STORE, PRIV_SUPER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'h0000_0001);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'h0000_00c7);
    // user page seen by supervisor without sum
    offer(ACT_REQUEST, 32'h0000_2000, ACC_LOAD, PRIV_SUPER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'hffff_ffff);
    // reserved write-only encoding
    offer(ACT_REQUEST, 32'h0000_2000, ACC_STORE, PRIV_USER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'h0000_0005);
    // misaligned megapage
    offer(ACT_REQUEST, 32'h0000_2000, ACC_LOAD, PRIV_SUPER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'h0000_0403);
    // entry not valid
    offer(ACT_REQUEST, 32'h0000_2000, ACC_LOAD, PRIV_SUPER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'h0000_0000);
    // mprv with an upper-half previous privilege
    drain();
    apply_setting(1'b1, 20'h00000, 1'b1, 1'b1, 1'b1, PRIV_RESERVED);
    offer(ACT_REQUEST, 32'h0000_3000, ACC_LOAD, PRIV_USER, 32'h0);
    offer(ACT_REQUEST, 32'h0040_0000, ACC_FETCH, PRIV_USER, 32'h0);
    offer(ACT_RESPONSE, 32'h0, ACC_FETCH, PRIV_USER, 32'h0000_0059);

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain();
      case (ph)
        0: apply_setting(1'b1, 20'h00000, 1'b0, 1'b0, 1'b0, PRIV_USER);
        1: apply_setting(1'b1, 20'hfffff, 1'b1, 1'b1, 1'b0, PRIV_SUPER);
        2: apply_setting(1'b1, 20'($urandom), 1'b1, 1'b0, 1'b1, PRIV_USER);
        3: apply_setting(1'b1, 20'($urandom), 1'b0, 1'b1, 1'b1, PRIV_SUPER);
        4: apply_setting(1'b1, 20'($urandom), 1'b1, 1'b1, 1'b1, PRIV_MACHINE);
        5: apply_setting(1'b0, 20'($urandom), 1'b0, 1'b0, 1'b0, PRIV_USER);
        6: apply_setting(1'b1, 20'($urandom), 1'b0, 1'b1, 1'b1, PRIV_RESERVED);
        default: apply_setting(1'b1, 20'($urandom), 1'($urandom), 1'($urandom),
                               1'($urandom), 2'($urandom));
      endcase
      no_gaps   = (ph == 4);
      no_stalls = (ph == 4 || ph == 5);
      // receiver holds off while requests keep coming
      if (ph == 1) hold_out = 1'b1;
      phase_end = items_sent + RandomItems / NumPhases;
      while (items_sent < phase_end) begin
        if (ph == 2 && !paused && items_sent + 25 >= phase_end) begin
          drain();
          paused = 1'b1;
        end
        random_walk();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("[sv32_page_table_walker_core] OK");
    end else begin
      $display("[sv32_page_table_walker_core] ERROR");
    end
    $finish;
  end

endmodule
